>>> rtl/core/euler_scale_translate_matrix_macros.svh
// Assertion macros shared by the transform block
`ifndef EULER_SCALE_TRANSLATE_MATRIX_MACROS_SVH
`define EULER_SCALE_TRANSLATE_MATRIX_MACROS_SVH

// condition must hold in the same cycle
`define ESM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transform check failed");

// condition must hold in the next cycle
`define ESM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("transform check failed");

`endif

>>> rtl/core/esm_pkg.sv
// Shared types, constants and tables for the transform block
`timescale 1ns / 1ps
package esm_pkg;
  localparam int TURN_UNITS    = 23040;
  localparam int QUARTER_UNITS = 5760;
  localparam int ATAN_ENTRIES  = 24;
  localparam int UNIT_W        = 18;
  localparam int CW            = 33;
  localparam int ZW            = 25;
  localparam int WIDE_W        = 54;
  localparam int T16_W         = 22;
  localparam int PROD_W        = 38;
  localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    unit_t c;
    unit_t s;
  } sincos_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] sz;
    logic [95:0]        pos;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_deg16(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:  v = 25'sd2949120;
      1:  v = 25'sd1740967;
      2:  v = 25'sd919879;
      3:  v = 25'sd466945;
      4:  v = 25'sd234379;
      5:  v = 25'sd117304;
      6:  v = 25'sd58666;
      7:  v = 25'sd29335;
      8:  v = 25'sd14668;
      9:  v = 25'sd7334;
      10: v = 25'sd3667;
      11: v = 25'sd1833;
      12: v = 25'sd917;
      13: v = 25'sd458;
      14: v = 25'sd229;
      15: v = 25'sd115;
      16: v = 25'sd57;
      17: v = 25'sd29;
      18: v = 25'sd14;
      19: v = 25'sd7;
      20: v = 25'sd4;
      21: v = 25'sd2;
      22: v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic unit_t clamp_unit(input logic signed [CW-1:0] v);
    unit_t r;
    priority if (v > 33'sd65536) begin
      r = 18'sd65536;
    end else if (v < -33'sd65536) begin
      r = -18'sd65536;
    end else begin
      r = v[UNIT_W-1:0];
    end
    return r;
  endfunction
endpackage

>>> rtl/core/euler_scale_translate_matrix.sv
// Data path runs angle reduction, CORDIC, products, sums, rounding, scale and clamp.
// One transform per cycle unless stalled; three CORDIC pipelines, one iteration per stage.
// The whole pipeline holds while a finished result waits and m_tready is low.
// Reset (rst, synchronous) clears the valid bits only; payload is not reset.
`timescale 1ns / 1ps
`include "euler_scale_translate_matrix_macros.svh"
module euler_scale_translate_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // scale_x, scale_y, scale_z, angle_x_deg, angle_y_deg, angle_z_deg, pos_x, pos_y, pos_z
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // axis_x_0..2, axis_y_0..2, axis_z_0..2 (24 bit each), trans_x, trans_y, trans_z
  output logic [311:0] m_tdata
);
  import esm_pkg::*;

  localparam int LANE_LAT = CORDIC_STAGES + 3;
  localparam int TOTAL    = LANE_LAT + 6;

  logic              en;
  logic [TOTAL-1:0]  vld;
  side_t             side [0:TOTAL-1];
  sincos_t           scx;
  sincos_t           scy;
  sincos_t           scz;
  logic signed [35:0] p   [0:7];
  unit_t              sy1;
  wide_t              ta  [0:8];
  wide_t              tb  [0:8];
  wide_t              ta_next [0:8];
  wide_t              tb_next [0:8];
  wide_t              tp0;
  wide_t              tp1;
  wide_t              tp2;
  wide_t              tp3;
  wide_t              tsum [0:8];
  logic signed [T16_W-1:0]  t16  [0:8];
  logic signed [PROD_W-1:0] prod [0:8];
  logic signed [23:0]       ent  [0:8];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOTAL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].sx  <= s_tdata[15:0];
      side[0].sy  <= s_tdata[31:16];
      side[0].sz  <= s_tdata[47:32];
      side[0].pos <= s_tdata[191:96];
      for (int k = 1; k < TOTAL; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  esm_cordic #(.STAGES(CORDIC_STAGES)) u_lane_x (
    .clk(clk), .en(en), .angle(s_tdata[63:48]), .sc(scx)
  );
  esm_cordic #(.STAGES(CORDIC_STAGES)) u_lane_y (
    .clk(clk), .en(en), .angle(s_tdata[79:64]), .sc(scy)
  );
  esm_cordic #(.STAGES(CORDIC_STAGES)) u_lane_z (
    .clk(clk), .en(en), .angle(s_tdata[95:80]), .sc(scz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= scy.c * scz.c;
      p[1] <= scz.s * scy.c;
      p[2] <= scx.s * scz.c;
      p[3] <= scx.c * scz.s;
      p[4] <= scx.s * scz.s;
      p[5] <= scx.c * scz.c;
      p[6] <= scx.s * scy.c;
      p[7] <= scy.c * scx.c;
      sy1  <= scy.s;
    end
  end

  assign tp0 = wide_t'(p[2]) * wide_t'(sy1);
  assign tp1 = wide_t'(p[4]) * wide_t'(sy1);
  assign tp2 = wide_t'(p[5]) * wide_t'(sy1);
  assign tp3 = wide_t'(p[3]) * wide_t'(sy1);

  always_comb begin
    ta_next[0] = wide_t'(p[0]) <<< 16;  tb_next[0] = '0;
    ta_next[1] = wide_t'(p[1]) <<< 16;  tb_next[1] = '0;
    ta_next[2] = -(wide_t'(sy1) <<< 32); tb_next[2] = '0;
    ta_next[3] = tp0;  tb_next[3] = -(wide_t'(p[3]) <<< 16);
    ta_next[4] = tp1;  tb_next[4] = wide_t'(p[5]) <<< 16;
    ta_next[5] = wide_t'(p[6]) <<< 16;  tb_next[5] = '0;
    ta_next[6] = tp2;  tb_next[6] = wide_t'(p[4]) <<< 16;
    ta_next[7] = tp3;  tb_next[7] = -(wide_t'(p[2]) <<< 16);
    ta_next[8] = wide_t'(p[7]) <<< 16;  tb_next[8] = '0;
  end

  for (genvar k = 0; k < 9; k++) begin : g_entry
    logic signed [15:0] scale;
    logic signed [PROD_W-1:0] rnd;
    if (k < 3) begin : g_sx
      assign scale = side[LANE_LAT+3].sx;
    end else if (k < 6) begin : g_sy
      assign scale = side[LANE_LAT+3].sy;
    end else begin : g_sz
      assign scale = side[LANE_LAT+3].sz;
    end
    assign rnd = (prod[k] + 38'sd128) >>> 8;

    always_ff @(posedge clk) begin
      if (en) begin
        ta[k]   <= ta_next[k];
        tb[k]   <= tb_next[k];
        tsum[k] <= ta[k] + tb[k];
        t16[k]  <= T16_W'((tsum[k] + (wide_t'(1) <<< 31)) >>> 32);
        prod[k] <= PROD_W'(scale) * PROD_W'(t16[k]);
        priority if (rnd > 38'sd8388607) begin
          ent[k] <= 24'sh7FFFFF;
        end else if (rnd < -38'sd8388608) begin
          ent[k] <= 24'sh800000;
        end else begin
          ent[k] <= rnd[23:0];
        end
      end
    end

    assign m_tdata[24*k +: 24] = ent[k];
  end

  assign m_tdata[311:216] = side[TOTAL-1].pos;

  `ESM_ASSERT_NEXT(a_stall_holds, !en, $stable(vld))
  `ESM_ASSERT_NOW(a_unit_range, vld[LANE_LAT-1], (scx.c <= 18'sd65536) && (scx.c >= -18'sd65536))
  `ESM_ASSERT_NEXT(a_zero_scale, en && vld[TOTAL-2] && (side[TOTAL-2].sx == 16'sd0), m_tdata[23:0] == 24'd0)
endmodule

>>> rtl/core/esm_cordic.sv
// Angle reduction and pipelined rotation CORDIC giving cosine and sine
`timescale 1ns / 1ps
module esm_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] angle,
  output esm_pkg::sincos_t   sc
);
  import esm_pkg::*;

  logic [14:0]           m;
  logic [14:0]           m_next;
  logic [1:0]            q_next;
  logic [12:0]           r_next;
  logic signed [CW-1:0]  x [0:STAGES];
  logic signed [CW-1:0]  y [0:STAGES];
  logic signed [ZW-1:0]  z [0:STAGES];
  logic [1:0]            q [0:STAGES];
  logic signed [CW-1:0]  xr;
  logic signed [CW-1:0]  yr;
  unit_t                 c;
  unit_t                 s;
  sincos_t               sc_next;
  logic signed [16:0]    a;

  assign a = 17'(angle);

  always_comb begin
    priority if (a < -17'sd23040) begin
      m_next = 15'(a + 17'sd46080);
    end else if (a < 17'sd0) begin
      m_next = 15'(a + 17'sd23040);
    end else if (a >= 17'sd23040) begin
      m_next = 15'(a - 17'sd23040);
    end else begin
      m_next = a[14:0];
    end
  end

  always_comb begin
    priority if (m >= 15'(3 * QUARTER_UNITS)) begin
      q_next = 2'd3;
      r_next = 13'(m - 15'(3 * QUARTER_UNITS));
    end else if (m >= 15'(2 * QUARTER_UNITS)) begin
      q_next = 2'd2;
      r_next = 13'(m - 15'(2 * QUARTER_UNITS));
    end else if (m >= 15'(QUARTER_UNITS)) begin
      q_next = 2'd1;
      r_next = 13'(m - 15'(QUARTER_UNITS));
    end else begin
      q_next = 2'd0;
      r_next = m[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m    <= m_next;
      q[0] <= q_next;
      z[0] <= ZW'({r_next, 10'b0});
    end
  end

  assign x[0] = GAIN_Q30;
  assign y[0] = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN = atan_deg16(i);
    always_ff @(posedge clk) begin
      if (en) begin
        q[i+1] <= q[i];
        if (!z[i][ZW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN;
        end
      end
    end
  end

  assign xr = (x[STAGES] + 33'sd8192) >>> 14;
  assign yr = (y[STAGES] + 33'sd8192) >>> 14;
  assign c  = clamp_unit(xr);
  assign s  = clamp_unit(yr);

  always_comb begin
    unique case (q[STAGES])
      2'd0: begin sc_next.c = c;  sc_next.s = s;  end
      2'd1: begin sc_next.c = -s; sc_next.s = c;  end
      2'd2: begin sc_next.c = -c; sc_next.s = -s; end
      default: begin sc_next.c = s; sc_next.s = -c; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc <= sc_next;
    end
  end
endmodule
